### hdl/sgrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrm_pkg
// Shared types, register indexes and the control store of the gain ramp mixer.
// ----------------------------------------------------------------------------
package sgrm_pkg;

  localparam int FRAC_BITS = 12;
  localparam int GAIN_W    = 16;
  localparam int SLEW_W    = 12;
  localparam int COUNT_W   = 4;
  localparam int NUM_W     = GAIN_W + SLEW_W;
  localparam int DIV_STEPS = GAIN_W;
  localparam int DCNT_W    = 5;
  localparam int CIDX_W    = 4;
  localparam int CDATA_W   = 16;
  localparam int STEP_W    = 4;

  localparam logic [CIDX_W-1:0] REG_CHANNEL_COUNT = 4'd0;
  localparam logic [CIDX_W-1:0] REG_SLEW_FRAMES   = 4'd1;
  localparam logic [CIDX_W-1:0] REG_OLD_GAIN      = 4'd2;
  localparam logic [CIDX_W-1:0] REG_NEW_GAIN      = 4'd3;

  localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
  localparam logic [SLEW_W-1:0]  RST_SLEW_FRAMES   = 12'd0;
  localparam logic [GAIN_W-1:0]  GAIN_ONE          = 16'd4096;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_NEW,
    OP_MUL_OLD,
    OP_SUM,
    OP_DIV,
    OP_MIX_MUL,
    OP_MIX_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_NO_RAMP,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic ramp_on;
    logic div_more;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] channel_count;
    logic [SLEW_W-1:0]  slew_frames;
    logic [GAIN_W-1:0]  old_gain;
    logic [GAIN_W-1:0]  new_gain;
  } cfg_t;

  localparam step_t S_WAIT = 4'd0;
  localparam step_t S_CHK  = 4'd1;
  localparam step_t S_MULN = 4'd2;
  localparam step_t S_MULO = 4'd3;
  localparam step_t S_SUM  = 4'd4;
  localparam step_t S_DIV  = 4'd5;
  localparam step_t S_MIXM = 4'd6;
  localparam step_t S_WOUT = 4'd7;
  localparam step_t S_MIXO = 4'd8;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_WAIT:  w = '{op: OP_LOAD,    cond: C_NO_INPUT, target: S_WAIT};
      S_CHK:   w = '{op: OP_NOP,     cond: C_NO_RAMP,  target: S_MIXM};
      S_MULN:  w = '{op: OP_MUL_NEW, cond: C_NEXT,     target: S_WAIT};
      S_MULO:  w = '{op: OP_MUL_OLD, cond: C_NEXT,     target: S_WAIT};
      S_SUM:   w = '{op: OP_SUM,     cond: C_NEXT,     target: S_WAIT};
      S_DIV:   w = '{op: OP_DIV,     cond: C_DIV_MORE, target: S_DIV};
      S_MIXM:  w = '{op: OP_MIX_MUL, cond: C_NEXT,     target: S_WAIT};
      S_WOUT:  w = '{op: OP_NOP,     cond: C_OUT_BUSY, target: S_WOUT};
      S_MIXO:  w = '{op: OP_MIX_OUT, cond: C_ALWAYS,   target: S_WAIT};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

### hdl/send_gain_ramp_mixer.sv
`timescale 1ns / 1ps
// steady gain: a sample passes the check, mix multiply, output wait and mix out steps in turn
// ramping adds two gain products, their sum and the divider; a new sample waits for mix out
// the ramping path is lengthened by the 16-step restoring divider for the gain fraction
// the output register takes one waiting result; the next item then holds until it goes
// synchronous active-low reset: registers to defaults, channel and ramp position to zero
// ----------------------------------------------------------------------------
// send_gain_ramp_mixer
// Mixes a source sample scaled by a ramped send gain into a bus sample.
// ----------------------------------------------------------------------------
module send_gain_ramp_mixer #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // source_sample, bus_sample
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // mixed_sample
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      out_tdata,
  // ramp_active
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sgrm_pkg::CIDX_W-1:0]            cfg_index,
  input  logic [sgrm_pkg::CDATA_W-1:0]           cfg_data
);
  import sgrm_pkg::*;

  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  cfg_t     cfg_r;
  logic     cfg_wr;
  logic     new_gain_wr;
  uword_t   uword;
  dp_stat_t stat;
  logic [SAMPLE_WIDTH-1:0] mixed;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign new_gain_wr = cfg_wr && (cfg_index == REG_NEW_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count <= RST_CHANNEL_COUNT;
      cfg_r.slew_frames   <= RST_SLEW_FRAMES;
      cfg_r.old_gain      <= GAIN_ONE;
      cfg_r.new_gain      <= GAIN_ONE;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[COUNT_W-1:0];
        REG_SLEW_FRAMES:   cfg_r.slew_frames   <= cfg_data[SLEW_W-1:0];
        REG_OLD_GAIN:      cfg_r.old_gain      <= cfg_data[GAIN_W-1:0];
        REG_NEW_GAIN:      cfg_r.new_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (uword.op == OP_LOAD);

  sgrm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .uword    (uword)
  );

  sgrm_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .uword       (uword),
    .cfg         (cfg_r),
    .new_gain_wr (new_gain_wr),
    .in_valid    (in_tvalid),
    .src_in      (in_tdata[SAMPLE_WIDTH-1:0]),
    .bus_in      (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .mixed       (mixed),
    .ramp_flag   (out_tuser),
    .stat        (stat)
  );

  assign out_tdata = OUT_W'(mixed);

endmodule

### hdl/sgrm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrm_seq
// Step counter over the control store, with conditional jumps on status.
// ----------------------------------------------------------------------------
module sgrm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sgrm_pkg::dp_stat_t stat,
  output sgrm_pkg::uword_t  uword
);
  import sgrm_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  assign uword = ucode(step_r);

  always_comb begin
    case (uword.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !in_valid;
      C_NO_RAMP:  take = !stat.ramp_on;
      C_DIV_MORE: take = stat.div_more;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b1;
    endcase
    step_nxt = take ? uword.target : step_t'(step_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### hdl/sgrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrm_dp
// Datapath: ramp gain multiplier, restoring divider, mix and saturation,
// frame position and the output register.
// ----------------------------------------------------------------------------
module sgrm_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sgrm_pkg::uword_t          uword,
  input  sgrm_pkg::cfg_t            cfg,
  input  logic                      new_gain_wr,
  input  logic                      in_valid,
  input  logic [SAMPLE_WIDTH-1:0]   src_in,
  input  logic [SAMPLE_WIDTH-1:0]   bus_in,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [SAMPLE_WIDTH-1:0]   mixed,
  output logic                      ramp_flag,
  output sgrm_pkg::dp_stat_t        stat
);
  import sgrm_pkg::*;

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MP_W   = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int TOT_W  = SAMPLE_WIDTH + GAIN_W + 2;
  localparam int SH_W   = TOT_W - FRAC_BITS;
  localparam int HEAD_W = SH_W - SAMPLE_WIDTH + 1;

  logic signed [SAMPLE_WIDTH-1:0] src_r;
  logic signed [SAMPLE_WIDTH-1:0] bus_r;
  logic [NUM_W-1:0]               prod_r;
  logic [NUM_W-1:0]               num_r;
  logic [SLEW_W-1:0]              rem_r;
  logic [GAIN_W-1:0]              quo_r;
  logic [DCNT_W-1:0]              dcnt_r;
  logic signed [MP_W-1:0]         mprod_r;
  logic [CH_W-1:0]                ch_r;
  logic [SLEW_W-1:0]              pos_r;
  logic                           out_valid_r;
  logic [SAMPLE_WIDTH-1:0]        mixed_r;
  logic                           ramp_r;

  logic                           active;
  logic [GAIN_W-1:0]              mul_a;
  logic [SLEW_W-1:0]              mul_b;
  logic [NUM_W-1:0]               mul_p;
  logic [NUM_W-1:0]               sum;
  logic [SLEW_W:0]                trial;
  logic                           ge;
  logic [GAIN_W-1:0]              gain;
  logic signed [TOT_W-1:0]        total;
  logic signed [TOT_W-1:0]        adj;
  logic signed [SH_W-1:0]         shr;
  logic [HEAD_W-1:0]              head;
  logic [SAMPLE_WIDTH-1:0]        sat;
  logic [DCNT_W-1:0]              count;
  logic                           last_ch;

  assign active = (cfg.slew_frames != '0) && (pos_r < cfg.slew_frames);

  // shared ramp multiplier
  always_comb begin
    if (uword.op == OP_MUL_NEW) begin
      mul_a = cfg.new_gain;
      mul_b = pos_r;
    end else begin
      mul_a = cfg.old_gain;
      mul_b = cfg.slew_frames - pos_r;
    end
    mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);
    sum   = num_r + prod_r;
  end

  // one quotient bit per step
  assign trial = {rem_r, quo_r[GAIN_W-1]};
  assign ge    = trial >= {1'b0, cfg.slew_frames};

  assign gain = active ? quo_r : cfg.new_gain;

  // truncate toward zero, then saturate
  always_comb begin
    total = $signed({{(GAIN_W-FRAC_BITS+2){bus_r[SAMPLE_WIDTH-1]}}, bus_r, {FRAC_BITS{1'b0}}})
            + $signed({mprod_r[MP_W-1], mprod_r});
    adj   = total + (total[TOT_W-1] ? TOT_W'((1 << FRAC_BITS) - 1) : '0);
    shr   = adj[TOT_W-1:FRAC_BITS];
    head  = shr[SH_W-1:SAMPLE_WIDTH-1];
    if (!shr[SH_W-1] && (head != '0)) begin
      sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else if (shr[SH_W-1] && (head != '1)) begin
      sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      sat = shr[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (cfg.channel_count == '0) begin
      count = DCNT_W'(1);
    end else if (DCNT_W'(cfg.channel_count) > DCNT_W'(MAX_CHANNELS)) begin
      count = DCNT_W'(MAX_CHANNELS);
    end else begin
      count = DCNT_W'(cfg.channel_count);
    end
    last_ch = (DCNT_W'(ch_r) + DCNT_W'(1)) >= count;
  end

  always_ff @(posedge clk) begin
    if (uword.op == OP_LOAD && in_valid) begin
      src_r <= src_in;
      bus_r <= bus_in;
    end
    if (uword.op == OP_MUL_NEW || uword.op == OP_MUL_OLD) begin
      prod_r <= mul_p;
    end
    if (uword.op == OP_MUL_OLD) begin
      num_r <= prod_r;
    end
    if (uword.op == OP_SUM) begin
      rem_r  <= sum[NUM_W-1:GAIN_W];
      quo_r  <= sum[GAIN_W-1:0];
      dcnt_r <= DCNT_W'(DIV_STEPS);
    end
    if (uword.op == OP_DIV) begin
      rem_r  <= ge ? SLEW_W'(trial - {1'b0, cfg.slew_frames}) : trial[SLEW_W-1:0];
      quo_r  <= {quo_r[GAIN_W-2:0], ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (uword.op == OP_MIX_MUL) begin
      mprod_r <= src_r * $signed({1'b0, gain});
    end
    if (uword.op == OP_MIX_OUT) begin
      mixed_r <= sat;
      ramp_r  <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (uword.op == OP_MIX_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (uword.op == OP_MIX_OUT) begin
        if (last_ch) begin
          ch_r <= '0;
        end else begin
          ch_r <= ch_r + 1'b1;
        end
      end
      if (new_gain_wr) begin
        pos_r <= '0;
      end else if (uword.op == OP_MIX_OUT && last_ch && active) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  assign stat.ramp_on  = active;
  assign stat.div_more = dcnt_r != DCNT_W'(1);
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign mixed     = mixed_r;
  assign ramp_flag = ramp_r;

endmodule

### test/sgrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrm_checker
// Watches the register, sample and result channels of the gain ramp mixer,
// keeps its own copy of the ramp state and checks every result in order.
// ----------------------------------------------------------------------------
module sgrm_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  // source_sample, bus_sample
  input  logic [31:0]                  in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  // mixed_sample
  input  logic [15:0]                  out_tdata,
  // ramp_active
  input  logic                         out_tuser,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [sgrm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sgrm_pkg::CDATA_W-1:0] cfg_data,
  output int                           errors,
  output int                           pending,
  output int                           mixes_checked,
  output int                           ramped_mixes
);

  import sgrm_pkg::*;

  localparam int MAX_LANES = 8;

  typedef struct packed {
    logic [15:0] mix;
    logic        ramp;
  } mix_result_t;

  logic [COUNT_W-1:0] lanes_per_frame;
  logic [SLEW_W-1:0]  ramp_frames;
  logic [GAIN_W-1:0]  level_from;
  logic [GAIN_W-1:0]  level_to;
  logic [2:0]         lane_idx;
  logic [SLEW_W-1:0]  ramp_pos;

  mix_result_t expected_mix_q[$];

  // advances lane and ramp position as the block does for one sample
  function automatic mix_result_t predict_mix(input logic signed [15:0] src,
                                              input logic signed [15:0] bus);
    int          lanes;
    logic        on;
    longint      level;
    longint      sum;
    mix_result_t r;
    lanes = int'(lanes_per_frame);
    if (lanes == 0) lanes = 1;
    if (lanes > MAX_LANES) lanes = MAX_LANES;
    on = (ramp_frames != 0) && (ramp_pos < ramp_frames);
    if (on) begin
      level = (longint'(level_to) * longint'(ramp_pos) +
               longint'(level_from) * longint'(ramp_frames - ramp_pos)) /
              longint'(ramp_frames);
    end else begin
      level = longint'(level_to);
    end
    sum = longint'(bus) * longint'(GAIN_ONE) + longint'(src) * level;
    sum = sum / (longint'(1) << FRAC_BITS);
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    if (int'(lane_idx) + 1 >= lanes) begin
      lane_idx = '0;
      if (on) ramp_pos = ramp_pos + 1'b1;
    end else begin
      lane_idx = lane_idx + 1'b1;
    end
    r.mix  = sum[15:0];
    r.ramp = on;
    return r;
  endfunction

  always @(posedge clk) begin
    mix_result_t exp_r;
    if (!rst_n) begin
      lanes_per_frame = RST_CHANNEL_COUNT;
      ramp_frames     = RST_SLEW_FRAMES;
      level_from      = GAIN_ONE;
      level_to        = GAIN_ONE;
      lane_idx        = '0;
      ramp_pos        = '0;
      expected_mix_q.delete();
      errors          = 0;
      mixes_checked   = 0;
      ramped_mixes    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: lanes_per_frame = cfg_data[COUNT_W-1:0];
          REG_SLEW_FRAMES:   ramp_frames = cfg_data[SLEW_W-1:0];
          REG_OLD_GAIN:      level_from = cfg_data[GAIN_W-1:0];
          REG_NEW_GAIN: begin
            level_to = cfg_data[GAIN_W-1:0];
            ramp_pos = '0;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_mix_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, got mix %0d ramp %0b",
                   $time, $signed(out_tdata), out_tuser);
        end else begin
          exp_r = expected_mix_q[0];
          expected_mix_q.delete(0);
          mixes_checked++;
          if (exp_r.ramp) ramped_mixes++;
          if (out_tdata !== exp_r.mix || out_tuser !== exp_r.ramp) begin
            errors++;
            $display("%0t: mismatch: expected mix %0d ramp %0b, got mix %0d ramp %0b",
                     $time, $signed(exp_r.mix), exp_r.ramp, $signed(out_tdata), out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_mix_q = {expected_mix_q, predict_mix(in_tdata[15:0], in_tdata[31:16])};
    end
    pending = expected_mix_q.size();
  end

endmodule

### test/tb_send_gain_ramp_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_send_gain_ramp_mixer
// Drives samples and register writes into the gain ramp mixer with random gaps
// on samples, stalls on results; the checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
module tb_send_gain_ramp_mixer;

  import sgrm_pkg::*;

  localparam int TARGET_SAMPLES = 1650;
  localparam logic [CIDX_W-1:0] FIRST_SPARE_REG = REG_NEW_GAIN + 1'b1;
  localparam logic [CIDX_W-1:0] LAST_SPARE_REG  = '1;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDATA_W-1:0]  cfg_data;

  int errors;
  int pending;
  int mixes_checked;
  int ramped_mixes;
  int samples_sent;
  int reg_writes;
  int stall_left;
  bit tx_gaps;
  bit rx_stalls;

  send_gain_ramp_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sgrm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .mixes_checked (mixes_checked),
    .ramped_mixes  (ramped_mixes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("DONE: errors detected");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 31) - 16);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_ONE;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // receiver back-pressure
  initial begin
    out_tready = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) stall_left--;
      else if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_tready = (stall_left == 0);
    end
  end

  task automatic send_sample(input logic [15:0] src, input logic [15:0] bus);
    int g;
    in_tdata  = {bus, src};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
    g = tx_gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every result is back, then let the datapath settle
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    logic [CIDX_W-1:0]  idx;
    logic [CDATA_W-1:0] data;
    int start;
    int n;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_gaps      = 1'b0;
    rx_stalls    = 1'b0;
    samples_sent = 0;
    reg_writes   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset levels: unity gain, two channels, no ramp
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hffff, 16'h0001);
    send_sample(16'h8000, 16'h7fff);
    wait_idle();

    // largest gain, truncation toward zero
    write_reg(REG_NEW_GAIN, 16'hffff);
    send_sample(16'hffff, 16'h0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    wait_idle();

    // longest ramp from silence to full
    write_reg(REG_CHANNEL_COUNT, 16'hfff1);
    write_reg(REG_SLEW_FRAMES, 16'hffff);
    write_reg(REG_OLD_GAIN, 16'h0000);
    write_reg(REG_NEW_GAIN, 16'hffff);
    send_sample(16'h7fff, 16'h0000);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'd12345, 16'hfffb);
    wait_idle();

    // short ramp that runs out
    write_reg(REG_SLEW_FRAMES, 16'd3);
    write_reg(REG_NEW_GAIN, 16'd40000);
    repeat (5) send_sample(16'h4000, 16'hc000);
    wait_idle();

    // zero channel count acts as one
    write_reg(REG_CHANNEL_COUNT, 16'd0);
    write_reg(REG_SLEW_FRAMES, 16'd0);
    send_sample(16'h1234, 16'h4321);
    wait_idle();

    // count above the limit, then shrunk below the channel position
    write_reg(REG_CHANNEL_COUNT, 16'd15);
    write_reg(REG_SLEW_FRAMES, 16'd10);
    write_reg(REG_NEW_GAIN, 16'd8192);
    repeat (3) send_sample(16'h7fff, 16'h0000);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    repeat (3) send_sample(16'h7fff, 16'h0000);
    wait_idle();

    // slew shortened below the position, spare indexes ignored
    write_reg(REG_SLEW_FRAMES, 16'd1);
    write_reg(FIRST_SPARE_REG, 16'hffff);
    write_reg(LAST_SPARE_REG, 16'h0000);
    send_sample(16'h7fff, 16'h0000);
    send_sample(16'h8000, 16'h0100);

    while (samples_sent < TARGET_SAMPLES) begin
      wait_idle();
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      start = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
        idx = CIDX_W'((start + k) % 4);
        case (idx)
          REG_CHANNEL_COUNT: begin
            case ($urandom_range(0, 7))
              0: data = 16'($urandom_range(0, 65535));
              1: data = 16'd8;
              default: data = 16'($urandom_range(1, 4));
            endcase
          end
          REG_SLEW_FRAMES: begin
            case ($urandom_range(0, 9))
              0: data = 16'($urandom_range(0, 65535));
              1: data = 16'd4095;
              2: data = '0;
              default: data = 16'($urandom_range(1, 12));
            endcase
          end
          default: data = pick_level();
        endcase
        if (idx == REG_NEW_GAIN ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) != 0))
          write_reg(idx, data);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CIDX_W'($urandom_range(int'(FIRST_SPARE_REG), int'(LAST_SPARE_REG))),
                  16'($urandom_range(0, 65535)));
      n = $urandom_range(8, 48);
      repeat (n) send_sample(pick_sample(), pick_sample());
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    $display("checked %0d mixed samples, %0d of them on a ramping gain, over %0d register writes",
             mixes_checked, ramped_mixes, reg_writes);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hdl/sgrm_pkg.sv
hdl/sgrm_seq.sv
hdl/sgrm_dp.sv
hdl/send_gain_ramp_mixer.sv
test/sgrm_checker.sv
test/tb_send_gain_ramp_mixer.sv
